@@ rtl/core/lbp_pkg.sv @@
// lbp_pkg: shared constants and types for the LBP pixel stream core.
// No dependencies; imported by every module of the core but the stream checker.
package lbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W  = 8;
  localparam int DIM_W  = 11;
  localparam int POS_W  = 10;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int FILL_W = COL_W + 1;
  localparam int CMP_W  = (DIM_W > FILL_W) ? DIM_W : FILL_W;
  localparam int ENT_W  = 2 * PIX_W;

  localparam logic [CMP_W-1:0] DIM_MIN  = CMP_W'(3);
  localparam logic [CMP_W-1:0] WIDTH_HI = CMP_W'(MAX_WIDTH);
  localparam logic [CMP_W-1:0] HEIGHT_HI = CMP_W'(MAX_HEIGHT);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last_col;
    logic             last_row;
    logic             mem_valid;
  } scan_info_t;

endpackage

@@ rtl/core/lbp_pixel_stream_core.sv @@
// lbp_pixel_stream_core: 3x3 local binary pattern over a raster gray pixel stream.
// Depends on lbp_pkg, lbp_scan_ctrl, lbp_line_mem and lbp_window.
//
// Takes one 8-bit pixel per clock in raster order and returns the LBP code of
// pixel (r-1,c-1) when pixel (r,c) is taken; row 0 and column 0 inputs give no
// result, border codes are zero and tlast marks the frame's last result. The
// line memory read is issued at the edge that takes the request, so its data
// meets the request in the compare and write-back stage, from where its result
// moves to the output register. A new pixel is taken every cycle: the single
// read and single write port of the 1024 x 16 line memory, which holds both
// line stores per column, each serve one request per cycle. A result held in
// the output register stalls the compare stage and then the input. Width and
// height (APB registers at 0x0 and 0x4) are clamped to 3..1024 and must be
// written only while the stream is idle; the core does not enforce this.
module lbp_pixel_stream_core import lbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [7:0] pattern_code, [17:8] out_row, [27:18] out_col
  output logic        out_tlast,   // frame_done
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  logic [DIM_W-1:0] width_r, height_r;
  logic             cfg_wr, accept;
  logic [COL_W-1:0] rd_addr, wr_addr;
  logic [ENT_W-1:0] rd_data, wr_data;
  logic             wr_en;
  scan_info_t       info;
  logic [PIX_W-1:0] code;
  logic [POS_W-1:0] row, col;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(640);
      height_r <= DIM_W'(480);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_IMAGE_WIDTH:  cfg_prdata = 32'(width_r);
      REG_IMAGE_HEIGHT: cfg_prdata = 32'(height_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  lbp_scan_ctrl u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .image_width  (width_r),
    .image_height (height_r),
    .rd_addr      (rd_addr),
    .info         (info)
  );

  lbp_line_mem u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  lbp_window u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .pixel     (in_tdata[PIX_W-1:0]),
    .info      (info),
    .rd_data   (rd_data),
    .ready     (in_tready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_code  (code),
    .out_row   (row),
    .out_col   (col),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'b0, col, row, code};

endmodule

@@ rtl/core/lbp_line_mem.sv @@
// lbp_line_mem: line store memory, one entry per column holding {upper, middle}.
// One write and one registered read per cycle. Depends on lbp_pkg.
module lbp_line_mem import lbp_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output logic [ENT_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [ENT_W-1:0] wr_data
);

  logic [ENT_W-1:0] mem [MAX_WIDTH];
  logic [ENT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/lbp_scan_ctrl.sv @@
// lbp_scan_ctrl: raster position counters, frame geometry clamp and line store fill count.
// Depends on lbp_pkg.
module lbp_scan_ctrl import lbp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  output logic [COL_W-1:0] rd_addr,
  output scan_info_t       info
);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CMP_W-1:0]  w_raw, h_raw, w_use, h_use;
  logic              last_col, last_row, mem_valid;

  assign w_raw = CMP_W'(image_width);
  assign h_raw = CMP_W'(image_height);

  always_comb begin
    if (w_raw < DIM_MIN)       w_use = DIM_MIN;
    else if (w_raw > WIDTH_HI) w_use = WIDTH_HI;
    else                       w_use = w_raw;
    if (h_raw < DIM_MIN)        h_use = DIM_MIN;
    else if (h_raw > HEIGHT_HI) h_use = HEIGHT_HI;
    else                        h_use = h_raw;
  end

  assign last_col  = CMP_W'(col_r) >= (w_use - CMP_W'(1));
  assign last_row  = CMP_W'(row_r) >= (h_use - CMP_W'(1));
  // entries at or above the fill count were never written since reset: read as zero
  assign mem_valid = FILL_W'(col_r) < fill_r;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    fill_nxt = fill_r;
    if (accept) begin
      if (!mem_valid) fill_nxt = FILL_W'(col_r) + FILL_W'(1);
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      fill_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign rd_addr        = col_r;
  assign info.col       = col_r;
  assign info.row       = row_r;
  assign info.last_col  = last_col;
  assign info.last_row  = last_row;
  assign info.mem_valid = mem_valid;

endmodule

@@ rtl/core/lbp_window.sv @@
// lbp_window: compare stage with 3x3 window, line store write-back and output register.
// Depends on lbp_pkg; fed by lbp_scan_ctrl and lbp_line_mem.
module lbp_window import lbp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [PIX_W-1:0] pixel,
  input  scan_info_t       info,
  input  logic [ENT_W-1:0] rd_data,
  output logic             ready,
  output logic             wr_en,
  output logic [COL_W-1:0] wr_addr,
  output logic [ENT_W-1:0] wr_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_code,
  output logic [POS_W-1:0] out_row,
  output logic [POS_W-1:0] out_col,
  output logic             out_last
);

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  scan_info_t       s1_info_r;
  logic [PIX_W-1:0] win_r [6];
  logic             out_valid_r;
  logic [PIX_W-1:0] out_code_r;
  logic [POS_W-1:0] out_row_r, out_col_r;
  logic             out_last_r;

  logic [PIX_W-1:0] t, m, b, ctr, code;
  logic             has_out, adv;

  assign has_out = (s1_info_r.row != '0) && (s1_info_r.col != '0);
  assign adv     = s1_valid_r && (!has_out || !out_valid_r || out_ready);
  assign ready   = !s1_valid_r || adv;

  assign t   = s1_info_r.mem_valid ? rd_data[ENT_W-1:PIX_W] : '0;
  assign m   = s1_info_r.mem_valid ? rd_data[PIX_W-1:0]     : '0;
  assign b   = s1_pix_r;
  assign ctr = win_r[4];

  always_comb begin
    code = '0;
    if ((s1_info_r.row >= ROW_W'(2)) && (s1_info_r.col >= COL_W'(2))) begin
      code = {win_r[0] >= ctr, win_r[3] >= ctr, t >= ctr, m >= ctr,
              b >= ctr, win_r[5] >= ctr, win_r[2] >= ctr, win_r[1] >= ctr};
    end
  end

  assign wr_en   = adv;
  assign wr_addr = s1_info_r.col;
  assign wr_data = {m, b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept)   s1_valid_r <= 1'b1;
      else if (adv) s1_valid_r <= 1'b0;
      if (adv && has_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= pixel;
      s1_info_r <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (adv) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= t;
      win_r[4] <= m;
      win_r[5] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_out) begin
      out_code_r <= code;
      out_row_r  <= POS_W'(s1_info_r.row - ROW_W'(1));
      out_col_r  <= POS_W'(s1_info_r.col - COL_W'(1));
      out_last_r <= s1_info_r.last_row && s1_info_r.last_col;
    end
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_last  = out_last_r;

endmodule

@@ rtl/core/lbp_stream_checker.sv @@
// lbp_stream_checker: port-level checks for lbp_pixel_stream_core, attached by bind.
// Depends only on the top level's ports.
module lbp_stream_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[17:8] == 10'd0 || out_tdata[27:18] == 10'd0)
    |-> out_tdata[7:0] == 8'd0)
    else $error("border pixel with nonzero code");

  a_last_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[17:8] != 10'd0 && out_tdata[27:18] != 10'd0)
    else $error("frame end on border position");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port not ready");

endmodule

bind lbp_pixel_stream_core lbp_stream_checker u_chk (.*);

@@ sim/tb_lbp_pixel_stream_core.sv @@
// tb_lbp_pixel_stream_core: self-checking bench for the LBP pixel stream core.
// Depends on lbp_pkg and lbp_pixel_stream_core; it models the line stores and
// the 3x3 window itself and checks every pattern code field by field.
module tb_lbp_pixel_stream_core;
  import lbp_pkg::*;

  localparam logic [2:0] REG_WIDTH  = 3'h0;
  localparam logic [2:0] REG_HEIGHT = 3'h4;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_GAP      = 11;

  // three 3x3 frames: flat, bright centre, mixed ties around the centre
  localparam logic [0:26][7:0] FRAME_PIX = {
    8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0,
    8'd100, 8'd99,  8'd101, 8'd100, 8'd100, 8'd0,   8'd255, 8'd99,  8'd100
  };

  typedef struct packed {
    logic [7:0] code;
    logic [9:0] row;
    logic [9:0] col;
    logic       done;
  } lbp_result_t;

  class lbp_code_board;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [7:0]       upper_line [MAX_WIDTH];
    logic [7:0]       middle_line [MAX_WIDTH];
    logic [7:0]       win [6];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    lbp_result_t      codes_due [$];
    int               mismatches;

    function new();
      width_reg  = 11'd640;
      height_reg = 11'd480;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      if (addr == REG_WIDTH) width_reg = data[DIM_W-1:0];
      else if (addr == REG_HEIGHT) height_reg = data[DIM_W-1:0];
    endfunction

    function void take_pixel(logic [7:0] b);
      int unsigned w, h, c, r;
      logic [7:0]  t, m, ctr, code;
      bit          last_col, last_row;
      lbp_result_t res;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      c = col_cnt;
      r = row_cnt;
      t = '0;
      m = '0;
      last_col = (c >= w - 1);
      last_row = (r >= h - 1);
      if (c < MAX_WIDTH) begin
        t = upper_line[c];
        m = middle_line[c];
        upper_line[c]  = m;
        middle_line[c] = b;
      end
      if (r >= 1 && c >= 1) begin
        code = '0;
        if (r >= 2 && c >= 2) begin
          ctr = win[4];
          code[7] = (win[0] >= ctr);
          code[6] = (win[3] >= ctr);
          code[5] = (t >= ctr);
          code[4] = (m >= ctr);
          code[3] = (b >= ctr);
          code[2] = (win[5] >= ctr);
          code[1] = (win[2] >= ctr);
          code[0] = (win[1] >= ctr);
        end
        res.code = code;
        res.row  = 10'(r - 1);
        res.col  = 10'(c - 1);
        res.done = last_row && last_col;
        codes_due.push_back(res);
      end
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = t;
      win[4] = m;
      win[5] = b;
      if (last_col) begin
        col_cnt = 0;
        row_cnt = last_row ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    // tdata: [7:0] pattern_code, [17:8] out_row, [27:18] out_col; tlast: frame_done
    function void check_code(logic [31:0] tdata, logic tlast);
      lbp_result_t due;
      if (codes_due.size() == 0) begin
        $error("result with no code pending: tdata=%h tlast=%b", tdata, tlast);
        mismatches++;
        return;
      end
      due = codes_due.pop_front();
      if (tdata[7:0] !== due.code) begin
        $error("pattern_code: expected %0d, got %0d", due.code, tdata[7:0]);
        mismatches++;
      end
      if (tdata[17:8] !== due.row) begin
        $error("out_row: expected %0d, got %0d", due.row, tdata[17:8]);
        mismatches++;
      end
      if (tdata[27:18] !== due.col) begin
        $error("out_col: expected %0d, got %0d", due.col, tdata[27:18]);
        mismatches++;
      end
      if (tlast !== due.done) begin
        $error("frame_done: expected %0d, got %0d", due.done, tlast);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lbp_code_board board;
  bit            hold_off_req = 1'b0;
  int            cycle_count = 0;

  lbp_pixel_stream_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // psel stays up across back-to-back writes; set_geometry drops it
  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.write_reg(addr, data);
  endtask

  task automatic set_geometry(input logic [31:0] w, input logic [31:0] h);
    while (board.codes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic send_pixel(input logic [7:0] pix, input int gap);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.take_pixel(pix);
  endtask

  task automatic stream_pixels(input int count, input bit burst, input bit narrow);
    logic [7:0] pix;
    for (int k = 0; k < count; k++) begin
      pix = narrow ? 8'($urandom_range(120, 123)) : 8'($urandom_range(0, 255));
      send_pixel(pix, burst ? 0 : $urandom_range(0, MAX_GAP));
    end
    in_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_dim();
    logic [31:0] v;
    case ($urandom_range(0, 15))
      0: v = 32'd2047;
      1: v = 32'd1024;
      2, 3: v = $urandom_range(0, 2);
      default: v = $urandom_range(3, 10);
    endcase
    if ($urandom_range(0, 3) == 0) v = v | ($urandom() & 32'hFFFF_F800);
    return v;
  endfunction

  initial begin : result_sink
    int gap;
    int seen;
    bit burst;
    seen  = 0;
    burst = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_off_req) begin
        gap = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end else begin
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      repeat (gap) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_code(out_tdata, out_tlast);
      seen++;
      if (seen % 64 == 0) burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stimulus
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_geometry(32'd3, 32'd3);
    for (int i = 0; i < 27; i++) send_pixel(FRAME_PIX[i], $urandom_range(0, MAX_GAP));
    in_tvalid <= 1'b0;

    for (int ph = 0; ph < 12; ph++) begin
      set_geometry(pick_dim(), pick_dim());
      stream_pixels($urandom_range(10, 60), $urandom_range(0, 3) == 0,
                    $urandom_range(0, 2) == 0);
    end

    // long output stall under a burst: the core must back up its input
    set_geometry(32'd8, 32'd8);
    hold_off_req = 1'b1;
    stream_pixels(64, 1'b1, 1'b0);

    while (board.codes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/lbp_pkg.sv
rtl/core/lbp_line_mem.sv
rtl/core/lbp_scan_ctrl.sv
rtl/core/lbp_window.sv
rtl/core/lbp_pixel_stream_core.sv
rtl/core/lbp_stream_checker.sv
sim/tb_lbp_pixel_stream_core.sv
